// ===== rtl/flc_pkg.sv =====
// Shared types and constants of the font list cache.
`timescale 1ns / 1ps

package flc_pkg;

  // Field widths of one cache entry.
  localparam int KEY_W  = 28;
  localparam int WIN_W  = 16;
  localparam int BASE_W = 12;

  // First allocation candidate and the step between candidates, modulo 4096.
  localparam logic [BASE_W-1:0] BASE_FIRST = 12'd1260;
  localparam logic [BASE_W-1:0] BASE_STEP  = 12'd260;

  // Update command for one cell; at most one bit is set.
  typedef struct packed {
    logic load;       // take the new entry
    logic take_prev;  // take the neighbor nearer the front
    logic take_next;  // take the neighbor nearer the back
  } cell_cmd_t;

endpackage

// ===== rtl/flc_cell.sv =====
// One entry cell of the font list cache: key, base and its comparators.
`timescale 1ns / 1ps

module flc_cell (
  input  logic                      clk,
  input  flc_pkg::cell_cmd_t        cmd,
  input  logic                      occ,
  input  logic                      release_mode,
  input  logic [flc_pkg::KEY_W-1:0]  cmp_key,
  input  logic [flc_pkg::BASE_W-1:0] cmp_base,
  input  logic [flc_pkg::KEY_W-1:0]  new_key,
  input  logic [flc_pkg::BASE_W-1:0] new_base,
  input  logic [flc_pkg::KEY_W-1:0]  prev_key,
  input  logic [flc_pkg::BASE_W-1:0] prev_base,
  input  logic [flc_pkg::KEY_W-1:0]  next_key,
  input  logic [flc_pkg::BASE_W-1:0] next_base,
  input  logic                      seen_in,
  output logic [flc_pkg::KEY_W-1:0]  key,
  output logic [flc_pkg::BASE_W-1:0] base,
  output logic                      match,
  output logic                      seen_out,
  output logic                      base_hit
);
  import flc_pkg::*;

  logic [KEY_W-1:0]  key_r;
  logic [KEY_W-1:0]  key_nxt;
  logic [BASE_W-1:0] base_r;
  logic [BASE_W-1:0] base_nxt;

  // Compare on the whole key for a lookup, on the window part for a release.
  always_comb begin
    if (release_mode) begin
      match = occ && (key_r[KEY_W-1:KEY_W-WIN_W] == cmp_key[KEY_W-1:KEY_W-WIN_W]);
    end else begin
      match = occ && (key_r == cmp_key);
    end
  end

  // The match chain tells each later cell that an earlier one matched.
  assign seen_out = seen_in | match;
  assign base_hit = occ && (base_r == cmp_base);

  // Entry moves between neighbors.
  always_comb begin
    key_nxt  = key_r;
    base_nxt = base_r;
    if (cmd.load) begin
      key_nxt  = new_key;
      base_nxt = new_base;
    end else if (cmd.take_prev) begin
      key_nxt  = prev_key;
      base_nxt = prev_base;
    end else if (cmd.take_next) begin
      key_nxt  = next_key;
      base_nxt = next_base;
    end
  end

  always_ff @(posedge clk) begin
    key_r  <= key_nxt;
    base_r <= base_nxt;
  end

  assign key  = key_r;
  assign base = base_r;

endmodule

// ===== rtl/font_list_lru_cache.sv =====
// Top level of the font list cache kept in most-recently-used order.
//
//   Channel | Direction | Ports        | Word contents
//   in      | input     | in_t*        | font request or window release
//   out     | output    | out_t*       | list base, hit/evict flags, last mark
//
// A lookup first latches the request, then compares in every cell and updates
// the row. A miss with free room then starts the base search and steps past
// each allocation candidate found in use (at most DEPTH-1), each one tested
// by the single broadcast base comparator row. A release emits one word per
// removed entry, one per cycle while the output is not stalled, and no word
// when nothing matches. A stalled output holds the engine in place. The input
// is ready again once the item is done.
// Reset (rst_n low, synchronous) empties the table; no clearing pass is needed.
`timescale 1ns / 1ps

module font_list_lru_cache #(
  parameter int DEPTH = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // window_id, italic, bold, font_size, font_family
  input  logic [0:0]  in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // list_base, evicted_base
  output logic [1:0]  out_tuser,  // hit, evicted
  output logic        out_tlast   // last
);
  import flc_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_LOOK  = 2'd1;
  localparam logic [1:0] S_ALLOC = 2'd2;
  localparam logic [1:0] S_REL   = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [BASE_W-1:0] cand_r, cand_nxt;
  logic [KEY_W-1:0] req_key_r;

  logic              out_valid_r;
  logic [BASE_W-1:0] out_base_r;
  logic [BASE_W-1:0] out_evb_r;
  logic              out_hit_r;
  logic              out_ev_r;
  logic              out_last_r;

  logic              emit;
  logic [BASE_W-1:0] e_base;
  logic [BASE_W-1:0] e_evb;
  logic              e_hit;
  logic              e_ev;
  logic              e_last;
  logic              upd_front;
  logic              upd_rel;
  logic [BASE_W-1:0] load_base;
  logic              out_free;
  logic              in_acc;

  cell_cmd_t         cmd   [DEPTH];
  logic [KEY_W-1:0]  key_q [DEPTH];
  logic [BASE_W-1:0] base_q[DEPTH];
  logic [DEPTH-1:0]  match;
  logic [DEPTH-1:0]  base_hit;
  logic [DEPTH-1:0]  occ;
  logic [DEPTH:0]    seen;

  logic              any_match;
  logic              second_match;
  logic              base_used;
  logic [BASE_W-1:0] sel_base;
  logic              full;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign full      = (count_r == CNT_W'(DEPTH));

  // Row of entry cells, front at index 0.
  assign seen[0] = 1'b0;
  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    logic [KEY_W-1:0]  p_key;
    logic [BASE_W-1:0] p_base;
    logic [KEY_W-1:0]  n_key;
    logic [BASE_W-1:0] n_base;

    if (j == 0) begin : g_front
      assign p_key  = req_key_r;
      assign p_base = load_base;
    end else begin : g_mid
      assign p_key  = key_q[j-1];
      assign p_base = base_q[j-1];
    end
    if (j == DEPTH - 1) begin : g_back
      assign n_key  = key_q[j];
      assign n_base = base_q[j];
    end else begin : g_inner
      assign n_key  = key_q[j+1];
      assign n_base = base_q[j+1];
    end

    assign occ[j] = (CNT_W'(j) < count_r);

    flc_cell u_cell (
      .clk          (clk),
      .cmd          (cmd[j]),
      .occ          (occ[j]),
      .release_mode (state_r == S_REL),
      .cmp_key      (req_key_r),
      .cmp_base     (cand_r),
      .new_key      (req_key_r),
      .new_base     (load_base),
      .prev_key     (p_key),
      .prev_base    (p_base),
      .next_key     (n_key),
      .next_base    (n_base),
      .seen_in      (seen[j]),
      .key          (key_q[j]),
      .base         (base_q[j]),
      .match        (match[j]),
      .seen_out     (seen[j+1]),
      .base_hit     (base_hit[j])
    );
  end

  // Base of the first matching cell and whether a later cell matches too.
  always_comb begin
    sel_base     = '0;
    second_match = 1'b0;
    for (int j = 0; j < DEPTH; j++) begin
      if (match[j] && !seen[j]) begin
        sel_base = sel_base | base_q[j];
      end
      second_match = second_match | (match[j] & seen[j]);
    end
  end

  assign any_match = seen[DEPTH];
  assign base_used = |base_hit;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    cand_nxt  = cand_r;
    emit      = 1'b0;
    e_base    = '0;
    e_evb     = '0;
    e_hit     = 1'b0;
    e_ev      = 1'b0;
    e_last    = 1'b0;
    upd_front = 1'b0;
    upd_rel   = 1'b0;
    load_base = sel_base;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = in_tuser[0] ? S_REL : S_LOOK;
        end
      end
      S_LOOK: begin
        if (any_match) begin
          if (out_free) begin
            emit      = 1'b1;
            e_base    = sel_base;
            e_hit     = 1'b1;
            e_last    = 1'b1;
            upd_front = 1'b1;
            state_nxt = S_IDLE;
          end
        end else if (full) begin
          if (out_free) begin
            load_base = base_q[DEPTH-1];
            emit      = 1'b1;
            e_base    = base_q[DEPTH-1];
            e_ev      = 1'b1;
            e_evb     = base_q[DEPTH-1];
            e_last    = 1'b1;
            upd_front = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          cand_nxt  = BASE_FIRST;
          state_nxt = S_ALLOC;
        end
      end
      S_ALLOC: begin
        load_base = cand_r;
        if (base_used) begin
          cand_nxt = cand_r + BASE_STEP;
        end else if (out_free) begin
          emit      = 1'b1;
          e_base    = cand_r;
          e_last    = 1'b1;
          upd_front = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          state_nxt = S_IDLE;
        end
      end
      S_REL: begin
        if (!any_match) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          emit      = 1'b1;
          e_base    = sel_base;
          e_last    = !second_match;
          upd_rel   = 1'b1;
          count_nxt = count_r - CNT_W'(1);
          if (!second_match) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Cell commands: move to front on lookup, close the gap on release.
  always_comb begin
    for (int j = 0; j < DEPTH; j++) begin
      cmd[j].load      = upd_front && (j == 0);
      cmd[j].take_prev = upd_front && (j != 0) && !seen[j];
      cmd[j].take_next = upd_rel && seen[j+1];
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request and result words.
  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
    if (in_acc) begin
      req_key_r <= {in_tdata[15:0], in_tdata[16], in_tdata[17],
                    in_tdata[25:18], in_tdata[27:26]};
    end
    if (emit) begin
      out_base_r <= e_base;
      out_evb_r  <= e_evb;
      out_hit_r  <= e_hit;
      out_ev_r   <= e_ev;
      out_last_r <= e_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_evb_r, out_base_r};
  assign out_tuser  = {out_ev_r, out_hit_r};
  assign out_tlast  = out_last_r;

endmodule
